@@ sv/lhkm_pkg.sv @@
// ----------------------------------------------------------------------------
// lhkm_pkg
// Shared types and codes for the link handshake / keepalive monitor.
// ----------------------------------------------------------------------------
`default_nettype none

package lhkm_pkg;

  // Link phase, one-hot
  typedef enum logic [2:0] {
    PH_AWAIT = 3'b001,
    PH_CONN  = 3'b010,
    PH_DEAD  = 3'b100
  } phase_t;

  // Event commands
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_FRAME = 2'd1;
  localparam logic [1:0] CMD_CLOSE = 2'd2;

  // Frame kinds
  localparam logic [1:0] KIND_HANDSHAKE = 2'd0;
  localparam logic [1:0] KIND_NORMAL    = 2'd1;
  localparam logic [1:0] KIND_HEARTBEAT = 2'd2;

  // Reported link status
  localparam logic [1:0] STAT_AWAIT = 2'd0;
  localparam logic [1:0] STAT_CONN  = 2'd1;
  localparam logic [1:0] STAT_DEAD  = 2'd2;

  // Error codes
  localparam logic [2:0] ERR_NONE          = 3'd0;
  localparam logic [2:0] ERR_BAD_HANDSHAKE = 3'd1;
  localparam logic [2:0] ERR_HS_TIMEOUT    = 3'd2;
  localparam logic [2:0] ERR_PROBES_FAILED = 3'd3;
  localparam logic [2:0] ERR_UNEXPECTED    = 3'd4;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_BITS = 3;
  localparam logic [CFG_IDX_BITS-1:0] REG_KEEPALIVE_EN = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_IDLE_LIMIT   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_PROBE_INTVL  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_PROBE_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_HS_LIMIT     = 3'd4;

  // Per-word action and status flags
  typedef struct packed {
    logic       reply;
    logic       heartbeat;
    logic       deliver;
    logic [1:0] status;
    logic [2:0] err;
  } result_flags_t;

  function automatic logic [1:0] status_of(phase_t ph);
    logic [1:0] s;
    unique case (ph)
      PH_AWAIT: s = STAT_AWAIT;
      PH_CONN:  s = STAT_CONN;
      PH_DEAD:  s = STAT_DEAD;
      default:  s = STAT_DEAD;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

@@ sv/lhkm_step.sv @@
// ----------------------------------------------------------------------------
// lhkm_step
// Next-state and result logic for one event word.
// ----------------------------------------------------------------------------
`default_nettype none

module lhkm_step #(
  parameter int unsigned TIMER_BITS = 24,
  parameter int unsigned PROBE_BITS = 8
) (
  input  wire logic [1:0]            command,
  input  wire logic [1:0]            msg_kind,
  // configuration
  input  wire logic                  keepalive_enabled,
  input  wire logic [TIMER_BITS-1:0] idle_limit,
  input  wire logic [TIMER_BITS-1:0] probe_interval,
  input  wire logic [PROBE_BITS-1:0] probe_limit,
  input  wire logic [TIMER_BITS-1:0] handshake_limit,
  // current state
  input  wire lhkm_pkg::phase_t      phase,
  input  wire logic                  probing,
  input  wire logic [PROBE_BITS-1:0] probe_counter,
  input  wire logic [TIMER_BITS-1:0] idle_timer,
  input  wire logic [TIMER_BITS-1:0] interval_timer,
  input  wire logic [TIMER_BITS-1:0] handshake_timer,
  // next state
  output lhkm_pkg::phase_t           phase_next,
  output logic                       probing_next,
  output logic [PROBE_BITS-1:0]      probe_counter_next,
  output logic [TIMER_BITS-1:0]      idle_timer_next,
  output logic [TIMER_BITS-1:0]      interval_timer_next,
  output logic [TIMER_BITS-1:0]      handshake_timer_next,
  output lhkm_pkg::result_flags_t    flags
);
  import lhkm_pkg::*;

  localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;
  localparam logic [PROBE_BITS-1:0] PROBE_MAX = '1;

  logic [TIMER_BITS-1:0] hs_inc;
  logic [TIMER_BITS-1:0] idle_inc;
  logic [TIMER_BITS-1:0] intvl_inc;

  // saturating increments
  assign hs_inc    = (handshake_timer == TIMER_MAX) ? TIMER_MAX : handshake_timer + 1'b1;
  assign idle_inc  = (idle_timer == TIMER_MAX)      ? TIMER_MAX : idle_timer + 1'b1;
  assign intvl_inc = (interval_timer == TIMER_MAX)  ? TIMER_MAX : interval_timer + 1'b1;

  always_comb begin
    phase_next           = phase;
    probing_next         = probing;
    probe_counter_next   = probe_counter;
    idle_timer_next      = idle_timer;
    interval_timer_next  = interval_timer;
    handshake_timer_next = handshake_timer;
    flags.reply          = 1'b0;
    flags.heartbeat      = 1'b0;
    flags.deliver        = 1'b0;
    flags.err            = ERR_NONE;

    unique case (phase)
      PH_AWAIT: begin
        if (command == CMD_TICK) begin
          handshake_timer_next = hs_inc;
          if (hs_inc >= handshake_limit) begin
            phase_next = PH_DEAD;
            flags.err  = ERR_HS_TIMEOUT;
          end
        end else if (command == CMD_FRAME) begin
          if (msg_kind == KIND_HANDSHAKE) begin
            flags.reply         = 1'b1;
            phase_next          = PH_CONN;
            probing_next        = 1'b0;
            probe_counter_next  = '0;
            idle_timer_next     = '0;
            interval_timer_next = '0;
          end else begin
            phase_next = PH_DEAD;
            flags.err  = ERR_BAD_HANDSHAKE;
          end
        end
      end
      PH_CONN: begin
        if (command == CMD_TICK) begin
          if (keepalive_enabled) begin
            if (probing) begin
              interval_timer_next = intvl_inc;
              if (intvl_inc > probe_interval) begin
                if (probe_counter < probe_limit) begin
                  flags.heartbeat     = 1'b1;
                  probe_counter_next  = (probe_counter == PROBE_MAX) ?
                                        PROBE_MAX : probe_counter + 1'b1;
                  interval_timer_next = '0;
                end else begin
                  phase_next = PH_DEAD;
                  flags.err  = ERR_PROBES_FAILED;
                end
              end
            end else begin
              idle_timer_next = idle_inc;
              if (idle_inc > idle_limit) begin
                probing_next        = 1'b1;
                probe_counter_next  = '0;
                interval_timer_next = '0;
              end
            end
          end
        end else if (command == CMD_FRAME) begin
          probing_next        = 1'b0;
          probe_counter_next  = '0;
          idle_timer_next     = '0;
          interval_timer_next = '0;
          if (msg_kind == KIND_NORMAL) begin
            flags.deliver = 1'b1;
          end else if (msg_kind == KIND_HEARTBEAT) begin
            flags.heartbeat = 1'b1;
          end else begin
            flags.err = ERR_UNEXPECTED;   // late handshake or unknown kind
          end
        end else if (command == CMD_CLOSE) begin
          phase_next = PH_DEAD;
        end
      end
      PH_DEAD: begin
        // everything ignored
      end
      default: begin
        phase_next = PH_DEAD;
      end
    endcase

    flags.status = status_of(phase_next);
  end

endmodule

`default_nettype wire

@@ sv/link_handshake_keepalive_monitor_unit.sv @@
// ----------------------------------------------------------------------------
// link_handshake_keepalive_monitor_unit
// Link-side handshake and keepalive monitor of a framed connection.
// ----------------------------------------------------------------------------
// Result: registered; the result word is offered in the cycle after its event word is accepted.
// Throughput: one event word per cycle while the downstream keeps taking results; the result register
//   frees itself when the downstream takes its word, so a full pipe still accepts input.
// Reset (rst, synchronous): link awaits handshake, timers and probe count
//   cleared, configuration back to its defaults, no result pending.
// ----------------------------------------------------------------------------
`default_nettype none

module link_handshake_keepalive_monitor_unit #(
  parameter int unsigned TIMER_BITS = 24,
  parameter int unsigned PROBE_BITS = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // event input
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [7:0]                        s_tdata,   // command[1:0], msg_kind[3:2]
  // result output
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // send_handshake_reply[0], send_heartbeat[1], deliver_frame[2],
  // link_status[4:3], fault_code[7:5], probes_sent[8+:PROBE_BITS], zero fill
  output logic [((8+PROBE_BITS+7)/8)*8-1:0]      m_tdata,
  // configuration write port
  input  wire logic                              cfg_we,
  input  wire logic [lhkm_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [((TIMER_BITS > PROBE_BITS) ? TIMER_BITS : PROBE_BITS)-1:0] cfg_data
);
  import lhkm_pkg::*;

  localparam int unsigned OUT_BITS = 8 + PROBE_BITS;
  localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic                  keepalive_enabled;
  logic [TIMER_BITS-1:0] idle_limit;
  logic [TIMER_BITS-1:0] probe_interval;
  logic [PROBE_BITS-1:0] probe_limit;
  logic [TIMER_BITS-1:0] handshake_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      keepalive_enabled <= 1'b0;
      idle_limit        <= TIMER_BITS'(60000);
      probe_interval    <= TIMER_BITS'(1000);
      probe_limit       <= PROBE_BITS'(3);
      handshake_limit   <= TIMER_BITS'(10000);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEEPALIVE_EN: keepalive_enabled <= cfg_data[0];
        REG_IDLE_LIMIT:   idle_limit        <= cfg_data[TIMER_BITS-1:0];
        REG_PROBE_INTVL:  probe_interval    <= cfg_data[TIMER_BITS-1:0];
        REG_PROBE_LIMIT:  probe_limit       <= cfg_data[PROBE_BITS-1:0];
        REG_HS_LIMIT:     handshake_limit   <= cfg_data[TIMER_BITS-1:0];
        default: ;        // writes past the register list are dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Link state
  // --------------------------------------------------------------------------
  phase_t                phase, phase_next;
  logic                  probing, probing_next;
  logic [PROBE_BITS-1:0] probe_counter, probe_counter_next;
  logic [TIMER_BITS-1:0] idle_timer, idle_timer_next;
  logic [TIMER_BITS-1:0] interval_timer, interval_timer_next;
  logic [TIMER_BITS-1:0] handshake_timer, handshake_timer_next;
  result_flags_t         flags;

  logic in_fire;

  // Accept whenever the result register is empty or is being drained.
  assign s_tready = ~m_tvalid | m_tready;
  assign in_fire  = s_tvalid & s_tready;

  lhkm_step #(
    .TIMER_BITS (TIMER_BITS),
    .PROBE_BITS (PROBE_BITS)
  ) u_step (
    .command              (s_tdata[1:0]),
    .msg_kind             (s_tdata[3:2]),
    .keepalive_enabled    (keepalive_enabled),
    .idle_limit           (idle_limit),
    .probe_interval       (probe_interval),
    .probe_limit          (probe_limit),
    .handshake_limit      (handshake_limit),
    .phase                (phase),
    .probing              (probing),
    .probe_counter        (probe_counter),
    .idle_timer           (idle_timer),
    .interval_timer       (interval_timer),
    .handshake_timer      (handshake_timer),
    .phase_next           (phase_next),
    .probing_next         (probing_next),
    .probe_counter_next   (probe_counter_next),
    .idle_timer_next      (idle_timer_next),
    .interval_timer_next  (interval_timer_next),
    .handshake_timer_next (handshake_timer_next),
    .flags                (flags)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_AWAIT;
      probing         <= 1'b0;
      probe_counter   <= '0;
      idle_timer      <= '0;
      interval_timer  <= '0;
      handshake_timer <= '0;
    end else if (in_fire) begin
      phase           <= phase_next;
      probing         <= probing_next;
      probe_counter   <= probe_counter_next;
      idle_timer      <= idle_timer_next;
      interval_timer  <= interval_timer_next;
      handshake_timer <= handshake_timer_next;
    end
  end

  // --------------------------------------------------------------------------
  // Result register: one result word per event word
  // --------------------------------------------------------------------------
  result_flags_t         res_flags;
  logic [PROBE_BITS-1:0] res_probes;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_flags  <= flags;
      res_probes <= probe_counter_next;
    end
  end

  assign m_tdata = OUT_W'({res_probes, res_flags.err, res_flags.status,
                           res_flags.deliver, res_flags.heartbeat, res_flags.reply});

endmodule

`default_nettype wire
